>>> sv/wpm_pkg.sv
// Shared package for the wildcard path matcher.
// Holds function codes, byte constants, controller state type and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package wpm_pkg;

  localparam int WPM_MAX_LEN = 64;

  localparam logic [1:0] FN_CLEAR_PATTERN = 2'd0;
  localparam logic [1:0] FN_ADD_PATTERN   = 2'd1;
  localparam logic [1:0] FN_ADD_PATH      = 2'd2;
  localparam logic [1:0] FN_EVALUATE      = 2'd3;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } wpm_state_t;

  typedef struct packed {
    logic pat_clr;
    logic pat_wr;
    logic path_wr;
    logic init;
    logic step;
    logic finish;
  } wpm_cmd_t;

  typedef struct packed {
    logic done;
  } wpm_stat_t;

endpackage

`default_nettype wire

>>> sv/wpm_ctrl.sv
// Controller state machine of the wildcard path matcher.
// Depends on wpm_pkg; drives wpm_cmd_t to the datapath, reads wpm_stat_t.
`default_nettype none

module wpm_ctrl
  import wpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  output logic            out_valid,
  input  wire logic       out_ready,
  output wpm_cmd_t        cmd,
  input  wire wpm_stat_t  stat
);

  wpm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FN_CLEAR_PATTERN: cmd.pat_clr = 1'b1;
            FN_ADD_PATTERN:   cmd.pat_wr  = 1'b1;
            FN_ADD_PATH:      cmd.path_wr = 1'b1;
            FN_EVALUATE: begin
              cmd.init  = 1'b1;
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        cmd.step  = 1'b1;
        state_nxt = stat.done ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        // hold the result until the output word is free
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/wpm_dp.sv
// Datapath of the wildcard path matcher: pattern and path memories,
// lengths, overflow flags, match pointers and result register. Uses wpm_pkg.
`default_nettype none

module wpm_dp
  import wpm_pkg::*;
#(
  parameter int MAX_LEN = WPM_MAX_LEN
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_byte_value,
  input  wire wpm_cmd_t   cmd,
  output wpm_stat_t       stat,
  output logic            out_matched,
  output logic            out_overflow
);

  localparam int W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int L = $clog2(MAX_LEN + 1);
  localparam logic [L-1:0] MaxLenL = L'(MAX_LEN);
  localparam logic [L-1:0] OneL    = L'(1);

  logic [7:0] pat_mem  [MAX_LEN];
  logic [7:0] path_mem [MAX_LEN];
  logic [7:0] pat_q_r, path_q_r;

  logic [L-1:0] pat_len_r, path_len_r;
  logic         pat_ovf_r, path_ovf_r, has_star_r;
  logic [L-1:0] pi_r, ui_r, resume_r, star_at_r;
  logic [L-1:0] pi_nxt, ui_nxt, resume_nxt, star_at_nxt;
  logic         have_star_r, have_star_nxt;
  logic         hit_r, hit_nxt;
  logic         out_matched_r, out_overflow_r;

  logic pat_full, path_full, ovf;
  logic pat_in, path_in, pat_star, byte_ok;

  assign pat_full  = (pat_len_r == MaxLenL);
  assign path_full = (path_len_r == MaxLenL);
  assign ovf       = pat_ovf_r | path_ovf_r;

  // memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.pat_wr && !pat_full) begin
      pat_mem[pat_len_r[W-1:0]] <= in_byte_value;
    end
    pat_q_r <= pat_mem[pi_r[W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.path_wr && !path_full) begin
      path_mem[path_len_r[W-1:0]] <= in_byte_value;
    end
    path_q_r <= path_mem[ui_r[W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      path_len_r <= '0;
      pat_ovf_r  <= 1'b0;
      path_ovf_r <= 1'b0;
      has_star_r <= 1'b0;
    end else begin
      if (cmd.pat_clr) begin
        pat_len_r  <= '0;
        pat_ovf_r  <= 1'b0;
        has_star_r <= 1'b0;
      end else if (cmd.pat_wr) begin
        if (pat_full) begin
          pat_ovf_r <= 1'b1;
        end else begin
          pat_len_r <= pat_len_r + OneL;
          if (in_byte_value == CH_STAR) begin
            has_star_r <= 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        path_len_r <= '0;
        path_ovf_r <= 1'b0;
      end else if (cmd.path_wr) begin
        if (path_full) begin
          path_ovf_r <= 1'b1;
        end else begin
          path_len_r <= path_len_r + OneL;
        end
      end
    end
  end

  assign pat_in   = (pi_r < pat_len_r);
  assign path_in  = (ui_r < path_len_r);
  assign pat_star = pat_in && (pat_q_r == CH_STAR);
  assign byte_ok  = pat_in && ((pat_q_r == CH_ANY) || (pat_q_r == path_q_r));

  // one matching step on the bytes read at pi_r and ui_r
  always_comb begin
    pi_nxt        = pi_r;
    ui_nxt        = ui_r;
    resume_nxt    = resume_r;
    star_at_nxt   = star_at_r;
    have_star_nxt = have_star_r;
    hit_nxt       = 1'b0;
    stat.done     = 1'b0;
    if (ovf) begin
      stat.done = 1'b1;
    end else if (!has_star_r) begin
      if (pat_len_r > path_len_r) begin
        stat.done = 1'b1;
      end else if (!pat_in) begin
        stat.done = 1'b1;
        hit_nxt   = 1'b1;
      end else if (pat_q_r != path_q_r) begin
        stat.done = 1'b1;
      end else begin
        pi_nxt = pi_r + OneL;
        ui_nxt = ui_r + OneL;
      end
    end else if (!path_in) begin
      // path consumed: skip trailing stars
      if (pat_star) begin
        pi_nxt = pi_r + OneL;
      end else begin
        stat.done = 1'b1;
        hit_nxt   = !pat_in;
      end
    end else if (pat_star) begin
      have_star_nxt = 1'b1;
      star_at_nxt   = pi_r;
      resume_nxt    = ui_r;
      pi_nxt        = pi_r + OneL;
    end else if (byte_ok) begin
      pi_nxt = pi_r + OneL;
      ui_nxt = ui_r + OneL;
    end else if (have_star_r) begin
      pi_nxt     = star_at_r + OneL;
      resume_nxt = resume_r + OneL;
      ui_nxt     = resume_r + OneL;
    end else begin
      stat.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      pi_r        <= '0;
      ui_r        <= '0;
      resume_r    <= '0;
      star_at_r   <= '0;
      have_star_r <= 1'b0;
    end else if (cmd.step) begin
      pi_r        <= pi_nxt;
      ui_r        <= ui_nxt;
      resume_r    <= resume_nxt;
      star_at_r   <= star_at_nxt;
      have_star_r <= have_star_nxt;
    end
    if (cmd.step && stat.done) begin
      hit_r <= hit_nxt;
    end
    if (cmd.finish) begin
      out_matched_r  <= hit_r;
      out_overflow_r <= ovf;
    end
  end

  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

endmodule

`default_nettype wire

>>> sv/wildcard_path_matcher.sv
// Wildcard path matcher top level: controller plus datapath.
// Depends on wpm_pkg, wpm_ctrl and wpm_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, in_func, in_byte_value) takes one word
//   per command: clear pattern, append pattern byte, append path byte, or
//   evaluate. Loads and clears finish in the accepting cycle.
//   Evaluate walks path and pattern by alternating a memory read state and
//   a decide state on the registered read data of the pattern and path
//   memories. A pattern without '*' is a prefix test. With '*', each
//   backtrack to the last star costs more steps. An overflowed store
//   answers with matched low, overflow high.
//   Result channel (out_valid/out_ready, out_matched, out_overflow) is a
//   register: while it stalls, load commands are still accepted; a finished
//   evaluation waits in its last state until the pending output word is
//   taken, then the path store is cleared.
//   Reset (synchronous, active low) empties both stores, clears overflow
//   flags and drops any pending output word. Memory contents stay undefined.
`default_nettype none

module wildcard_path_matcher
  import wpm_pkg::*;
#(
  parameter int MAX_LEN = WPM_MAX_LEN
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_byte_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched,
  output logic            out_overflow
);

  wpm_cmd_t  cmd;
  wpm_stat_t stat;

  // sequence loads, evaluation steps and the result handoff
  wpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // stores, pointers and the match decision
  wpm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte_value (in_byte_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_matched   (out_matched),
    .out_overflow  (out_overflow)
  );

endmodule

`default_nettype wire

>>> sv/wpm_chk.sv
// Port-level checker for the wildcard path matcher, bound to the top level.
// Depends on wpm_pkg and wildcard_path_matcher.
`default_nettype none

module wpm_chk
  import wpm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_matched,
  input wire logic       out_overflow
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched) && $stable(out_overflow))
    else $error("result word changed while stalled");

  // overflow forces a miss
  a_ovf_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_matched)
    else $error("matched set together with overflow");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an accepted evaluate keeps the input side busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FN_EVALUATE) |=> !in_ready)
    else $error("input ready right after evaluate");

endmodule

bind wildcard_path_matcher wpm_chk u_wpm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_func      (in_func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_matched  (out_matched),
  .out_overflow (out_overflow)
);

`default_nettype wire

>>> tb/wpm_tb_pkg.sv
// Scoreboard for the wildcard path matcher testbench.
// Tracks pattern and path stores, predicts each evaluation verdict and checks
// the result words against them. Depends on wpm_pkg.

package wpm_tb_pkg;

  import wpm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  class match_tracker;

    bit [7:0]    pat_mem [WPM_MAX_LEN];
    int unsigned pat_len;
    bit          pat_ovf;
    bit [7:0]    path_mem [WPM_MAX_LEN];
    int unsigned path_len;
    bit          path_ovf;

    verdict_t    verdict_q [$];
    int unsigned evals_noted;
    int unsigned verdicts_checked;
    int unsigned hits;
    int unsigned overflows;
    int unsigned mismatches;

    function new();
      pat_len          = 0;
      pat_ovf          = 1'b0;
      path_len         = 0;
      path_ovf         = 1'b0;
      evals_noted      = 0;
      verdicts_checked = 0;
      hits             = 0;
      overflows        = 0;
      mismatches       = 0;
    endfunction

    function bit pattern_has_star();
      for (int unsigned k = 0; k < pat_len; k++) begin
        if (pat_mem[k] == CH_STAR) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Literal prefix test: '?' is an ordinary byte here.
    function bit prefix_hit();
      if (pat_len > path_len) return 1'b0;
      for (int unsigned k = 0; k < pat_len; k++) begin
        if (pat_mem[k] != path_mem[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Greedy glob walk, backtracking to the latest star.
    function bit glob_hit();
      int unsigned ui;
      int unsigned pi;
      int unsigned resume;
      int unsigned star_at;
      bit          seen_star;
      ui        = 0;
      pi        = 0;
      resume    = 0;
      star_at   = 0;
      seen_star = 1'b0;
      while (ui < path_len) begin
        if (pi < pat_len && pat_mem[pi] == CH_STAR) begin
          seen_star = 1'b1;
          star_at   = pi;
          resume    = ui;
          pi++;
        end else if (pi < pat_len &&
                     (pat_mem[pi] == CH_ANY || pat_mem[pi] == path_mem[ui])) begin
          ui++;
          pi++;
        end else if (seen_star) begin
          pi = star_at + 1;
          resume++;
          ui = resume;
        end else begin
          return 1'b0;
        end
      end
      while (pi < pat_len && pat_mem[pi] == CH_STAR) pi++;
      return (pi == pat_len);
    endfunction

    function void absorb_word(logic [1:0] fn, logic [7:0] val);
      verdict_t v;
      case (fn)
        FN_CLEAR_PATTERN: begin
          pat_len = 0;
          pat_ovf = 1'b0;
        end
        FN_ADD_PATTERN: begin
          if (pat_len < WPM_MAX_LEN) begin
            pat_mem[pat_len] = val;
            pat_len++;
          end else begin
            pat_ovf = 1'b1;
          end
        end
        FN_ADD_PATH: begin
          if (path_len < WPM_MAX_LEN) begin
            path_mem[path_len] = val;
            path_len++;
          end else begin
            path_ovf = 1'b1;
          end
        end
        default: begin
          v.overflow = pat_ovf || path_ovf;
          v.matched  = 1'b0;
          if (!v.overflow) v.matched = pattern_has_star() ? glob_hit() : prefix_hit();
          verdict_q = {verdict_q, v};
          evals_noted++;
          if (v.matched) hits++;
          if (v.overflow) overflows++;
          path_len = 0;
          path_ovf = 1'b0;
        end
      endcase
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_verdict(logic got_matched, logic got_overflow);
      verdict_t want;
      verdicts_checked++;
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("result word %0d with no evaluation pending",
                                verdicts_checked));
        return;
      end
      want = verdict_q.pop_front();
      if (got_matched !== want.matched)
        flag_mismatch($sformatf("result word %0d: matched %b, want %b",
                                verdicts_checked, got_matched, want.matched));
      if (got_overflow !== want.overflow)
        flag_mismatch($sformatf("result word %0d: overflow %b, want %b",
                                verdicts_checked, got_overflow, want.overflow));
    endtask

  endclass

endpackage

>>> tb/tb.sv
// Top-level testbench for wildcard_path_matcher: drives command words with
// random idling, stalls the result channel, and checks every verdict.
// Depends on wpm_pkg, wpm_tb_pkg and the wildcard_path_matcher RTL.

module tb;

  import wpm_pkg::*;
  import wpm_tb_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [7:0] in_byte_value;
  logic       out_valid;
  logic       out_ready;
  logic       out_matched;
  logic       out_overflow;

  match_tracker tracker;

  // Stimulus control for the driver and the result sink.
  bit          calm;        // final stretch: no idling on either side
  bit          gappy;       // current sequence may idle on the input side
  bit          sink_gappy;  // result side may stall in this stretch
  int unsigned stall_left;
  int unsigned words_sent;

  // Scratch for building sequences.
  logic [7:0]  shaped [$];
  int unsigned seq_len;
  int unsigned target_len;
  int unsigned roll;
  bit          star_ok;
  bit          starry;
  logic [7:0]  pc;

  wildcard_path_matcher DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_byte_value(in_byte_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_matched  (out_matched),
    .out_overflow (out_overflow)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Mostly a small path alphabet so patterns and paths line up; sometimes any byte.
  function automatic logic [7:0] pick_glyph();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) return "a";
    if (r < 11) return "b";
    if (r < 15) return "/";
    if (r < 17) return ".";
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one word at the falling edge, hold it until accepted, then note it.
  // Ends on a falling edge with valid still high.
  task automatic send_word(logic [1:0] fn, logic [7:0] val);
    int unsigned gap;
    gap = 0;
    if (!calm && gappy && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_byte_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.absorb_word(fn, val);
    words_sent++;
    @(negedge clk);
  endtask

  // Result sink: drive ready at the falling edge, stalling in random bursts.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    sink_gappy = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && sink_gappy && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 19);
      end
      if ($urandom_range(0, 63) == 0) sink_gappy = !sink_gappy;
    end
  end

  // Check each result word at the rising edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_verdict(out_matched, out_overflow);
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #60000000;
    $display("wildcard_path_matcher regression: fail");
    $finish;
  end

  initial begin
    tracker       = new();
    in_valid      = 1'b0;
    in_func       = FN_CLEAR_PATTERN;
    in_byte_value = 8'h00;
    rst_n         = 1'b0;
    calm          = 1'b0;
    gappy         = 1'b1;
    words_sent    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pattern against empty path matches as a prefix.
    send_word(FN_EVALUATE, 8'hFF);
    // Starless pattern: '?' must match literally.
    send_word(FN_CLEAR_PATTERN, 8'hFF);
    send_word(FN_ADD_PATTERN, "a");
    send_word(FN_ADD_PATTERN, CH_ANY);
    send_word(FN_ADD_PATH, "a");
    send_word(FN_ADD_PATH, CH_ANY);
    send_word(FN_ADD_PATH, "x");
    send_word(FN_EVALUATE, 8'h00);
    // Same pattern kept; '?' against 'b' must now fail.
    send_word(FN_ADD_PATH, "a");
    send_word(FN_ADD_PATH, "b");
    send_word(FN_ADD_PATH, "x");
    send_word(FN_EVALUATE, 8'hFF);
    // Star pattern with extreme bytes and a trailing star; the star in the
    // path is swallowed by the wildcard.
    send_word(FN_CLEAR_PATTERN, 8'h00);
    send_word(FN_ADD_PATTERN, 8'h00);
    send_word(FN_ADD_PATTERN, CH_STAR);
    send_word(FN_ADD_PATTERN, 8'hFF);
    send_word(FN_ADD_PATTERN, CH_STAR);
    send_word(FN_ADD_PATH, 8'h00);
    send_word(FN_ADD_PATH, "a");
    send_word(FN_ADD_PATH, CH_STAR);
    send_word(FN_ADD_PATH, 8'hFF);
    send_word(FN_EVALUATE, 8'h00);
    // Empty path against a star pattern that starts with a literal.
    send_word(FN_EVALUATE, 8'hFF);

    // Random: mostly load/evaluate sequences, some raw noise words.
    while (words_sent < 500 || tracker.evals_noted < 48) begin
      gappy = ($urandom_range(0, 2) != 0);
      if (words_sent >= 440) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        // Reload the pattern about half the time; keep it otherwise.
        if ($urandom_range(0, 1) == 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 80) seq_len = $urandom_range(0, 8);
          else if (roll < 93) seq_len = $urandom_range(9, 30);
          else seq_len = $urandom_range(60, 68);
          star_ok = ($urandom_range(0, 4) < 3);
          send_word(FN_CLEAR_PATTERN, 8'($urandom_range(0, 255)));
          repeat (seq_len) begin
            roll = $urandom_range(0, 99);
            if (star_ok && roll < 20) pc = CH_STAR;
            else if (roll < 35) pc = CH_ANY;
            else pc = pick_glyph();
            send_word(FN_ADD_PATTERN, pc);
          end
        end
        // Build a path that fits the pattern, then maybe break it.
        starry = tracker.pattern_has_star();
        shaped.delete();
        for (int unsigned k = 0; k < tracker.pat_len; k++) begin
          pc = tracker.pat_mem[k];
          if (starry && pc == CH_STAR) begin
            repeat ($urandom_range(0, 3)) shaped = {shaped, pick_glyph()};
          end else if (starry && pc == CH_ANY) begin
            shaped = {shaped, pick_glyph()};
          end else begin
            shaped = {shaped, pc};
          end
        end
        if (!starry) repeat ($urandom_range(0, 3)) shaped = {shaped, pick_glyph()};
        roll = $urandom_range(0, 99);
        if (roll < 12 && shaped.size() > 0) begin
          shaped[$urandom_range(0, shaped.size() - 1)] = pick_glyph();
        end else if (roll < 20 && shaped.size() > 0) begin
          shaped.delete($urandom_range(0, shaped.size() - 1));
        end else if (roll < 26) begin
          shaped = {shaped, pick_glyph()};
        end else if (roll < 31) begin
          // Fill the path to near, at or past capacity.
          target_len = $urandom_range(60, 68);
          while (shaped.size() < target_len) shaped = {shaped, pick_glyph()};
        end
        while (shaped.size() > 70) shaped.pop_back();
        foreach (shaped[i]) send_word(FN_ADD_PATH, shaped[i]);
        send_word(FN_EVALUATE, 8'($urandom_range(0, 255)));
      end
    end

    // Drop valid, drain the verdicts, then watch for stray result words.
    in_valid <= 1'b0;
    calm = 1'b1;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Drove %0d command words; %0d evaluations checked (%0d matched, %0d overflowed).",
             words_sent, tracker.verdicts_checked, tracker.hits, tracker.overflows);
    $display("Mismatches found: %0d", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("wildcard_path_matcher regression: pass");
    end else begin
      $display("wildcard_path_matcher regression: fail");
    end
    $finish;
  end

endmodule
